/* hdl/bphf_pkg.sv */
// ----------------------------------------------------------------------------
// bphf_pkg
// Shared types and constants of the byte pattern hit finder.
// ----------------------------------------------------------------------------
package bphf_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;

  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int PAT_LEN_W    = 5;
  localparam int PAT_BYTES    = 16;
  localparam int SKIP_W       = 4;
  localparam int HIT_OFFSET_W = 32;
  localparam int HIT_NUMBER_W = 10;
  localparam int OUT_TDATA_W  = 48;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [PAT_LEN_W-1:0]    PATTERN_LEN_RESET = 5'd1;
  localparam logic [HIT_NUMBER_W-1:0] HIT_LIMIT_RESET   = 10'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_HIT_LIMIT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    first;
    logic                    match;
    logic [SKIP_W-1:0]       skip_len;
    logic [HIT_OFFSET_W-1:0] start_offset;
  } entry_t;

endpackage

/* hdl/bphf_front.sv */
// ----------------------------------------------------------------------------
// bphf_front
// Byte window, fill count and offset; classifies each byte as match or not.
// ----------------------------------------------------------------------------
module bphf_front #(
  parameter int MAX_PATTERN_BYTES = bphf_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = bphf_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_accept,
  input  logic [7:0]                            data_byte,
  input  logic                                  first_byte,
  input  logic [bphf_pkg::CFG_DATA_W-1:0]       pattern_low,
  input  logic [bphf_pkg::CFG_DATA_W-1:0]       pattern_high,
  input  logic [bphf_pkg::PAT_LEN_W-1:0]        pattern_len,
  output bphf_pkg::entry_t                      entry
);
  import bphf_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [7:0]             window_r   [MAX_PATTERN_BYTES];
  logic [7:0]             window_nxt [MAX_PATTERN_BYTES];
  logic [7:0]             pat_bytes  [PAT_BYTES];
  logic [PAT_LEN_W-1:0]   pat_idx    [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  logic [FILL_W-1:0]      fill_r, fill_base, fill_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_cur, start_offset;
  logic [PAT_LEN_W-1:0]   len_eff;
  logic                   match;

  always_comb begin
    for (int j = 0; j < PAT_BYTES / 2; j++) begin
      pat_bytes[j]                 = pattern_low[j*8 +: 8];
      pat_bytes[j + PAT_BYTES / 2] = pattern_high[j*8 +: 8];
    end
  end

  always_comb begin
    if (pattern_len > PAT_LEN_W'(MAX_PATTERN_BYTES)) begin
      len_eff = PAT_LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = pattern_len;
    end
  end

  always_comb begin
    window_nxt[0] = data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  always_comb begin
    fill_base = first_byte ? '0 : fill_r;
    if (fill_base == FILL_W'(MAX_PATTERN_BYTES)) begin
      fill_nxt = fill_base;
    end else begin
      fill_nxt = fill_base + FILL_W'(1);
    end
  end

  // window position k holds the byte that must equal pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      pat_idx[k] = len_eff - PAT_LEN_W'(1) - PAT_LEN_W'(k);
      pos_ok[k]  = (PAT_LEN_W'(k) >= len_eff) ||
                   (window_nxt[k] == pat_bytes[pat_idx[k][SKIP_W-1:0]]);
    end
  end

  assign match = (len_eff != '0) && (PAT_LEN_W'(fill_nxt) >= len_eff) && (&pos_ok);

  assign offset_cur   = first_byte ? '0 : offset_r;
  assign start_offset = offset_cur - OFFSET_BITS'(len_eff - PAT_LEN_W'(1));

  always_comb begin
    entry.first        = first_byte;
    entry.match        = match;
    entry.skip_len     = SKIP_W'(len_eff - PAT_LEN_W'(1));
    entry.start_offset = HIT_OFFSET_W'(start_offset);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      offset_r <= '0;
    end else if (in_accept) begin
      fill_r   <= fill_nxt;
      offset_r <= offset_cur + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      window_r <= window_nxt;
    end
  end

endmodule

/* hdl/bphf_queue.sv */
// ----------------------------------------------------------------------------
// bphf_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module bphf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bphf_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output bphf_pkg::entry_t head
);
  import bphf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hdl/bphf_back.sv */
// ----------------------------------------------------------------------------
// bphf_back
// Applies overlap skipping and the hit limit, numbers hits, holds the result.
// ----------------------------------------------------------------------------
module bphf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  bphf_pkg::entry_t                  q_head,
  output logic                              q_pop,
  input  logic [bphf_pkg::HIT_NUMBER_W-1:0] hit_limit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bphf_pkg::HIT_OFFSET_W-1:0] hit_offset,
  output logic [bphf_pkg::HIT_NUMBER_W-1:0] hit_number
);
  import bphf_pkg::*;

  logic [SKIP_W-1:0]       skip_r, skip_cur, skip_nxt;
  logic [HIT_NUMBER_W-1:0] hits_r, hits_cur, hits_nxt;
  logic                    out_valid_r;
  logic [HIT_OFFSET_W-1:0] hit_offset_r;
  logic [HIT_NUMBER_W-1:0] hit_number_r;
  logic                    emit;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    skip_cur = q_head.first ? '0 : skip_r;
    hits_cur = q_head.first ? '0 : hits_r;
    skip_nxt = skip_cur;
    hits_nxt = hits_cur;
    emit     = 1'b0;
    if (skip_cur != '0) begin
      skip_nxt = skip_cur - SKIP_W'(1);
    end else if (q_head.match) begin
      skip_nxt = q_head.skip_len;
      if (hits_cur < hit_limit) begin
        hits_nxt = hits_cur + HIT_NUMBER_W'(1);
        emit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        skip_r <= skip_nxt;
        hits_r <= hits_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      hit_offset_r <= q_head.start_offset;
      hit_number_r <= hits_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign hit_offset = hit_offset_r;
  assign hit_number = hit_number_r;

endmodule

/* hdl/byte_pattern_hit_finder.sv */
// ----------------------------------------------------------------------------
// byte_pattern_hit_finder
// Non-overlapping, leftmost-first search for a 1 to 16 byte pattern in a
// byte stream; reports start offset and ordinal of each hit up to a limit.
//
//   channel | direction | payload
//   in_     | slave     | tdata[7:0] data_byte, tuser[0] first_byte
//   out_    | master    | tdata[31:0] hit_offset, [41:32] hit_number
//   cfg_    | write     | index 0..3: pattern_low, pattern_high, len, limit
//
// One byte per cycle sustained while the queue has room; the front compares
// the full window against the pattern in the cycle a byte is taken, the back
// updates skip and hit counters as each queued byte is popped. A hit is
// registered on out_ at the edge its last byte leaves the queue.
// Reset is synchronous and needs a single cycle.
// A stalled out_ fills the four-entry queue, then in_tready drops.
// ----------------------------------------------------------------------------
module byte_pattern_hit_finder #(
  parameter int MAX_PATTERN_BYTES = bphf_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = bphf_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] data_byte
  input  logic                                 in_tuser,   // [0] first_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bphf_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] hit_offset,
                                                           // [41:32] hit_number
  input  logic                                 cfg_wr_en,
  input  logic [bphf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bphf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bphf_pkg::*;

  logic [CFG_DATA_W-1:0]   pattern_low_r, pattern_high_r;
  logic [PAT_LEN_W-1:0]    pattern_len_r;
  logic [HIT_NUMBER_W-1:0] hit_limit_r;

  logic                    in_accept;
  entry_t                  front_entry, q_head;
  logic                    q_full, q_not_empty, q_pop;
  logic [HIT_OFFSET_W-1:0] hit_offset;
  logic [HIT_NUMBER_W-1:0] hit_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
      pattern_len_r  <= PATTERN_LEN_RESET;
      hit_limit_r    <= HIT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low_r  <= cfg_wdata;
        REG_PATTERN_HIGH: pattern_high_r <= cfg_wdata;
        REG_PATTERN_LEN:  pattern_len_r  <= cfg_wdata[PAT_LEN_W-1:0];
        REG_HIT_LIMIT:    hit_limit_r    <= cfg_wdata[HIT_NUMBER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  bphf_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .data_byte    (in_tdata),
    .first_byte   (in_tuser),
    .pattern_low  (pattern_low_r),
    .pattern_high (pattern_high_r),
    .pattern_len  (pattern_len_r),
    .entry        (front_entry)
  );

  bphf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  bphf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .hit_limit   (hit_limit_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .hit_offset  (hit_offset),
    .hit_number  (hit_number)
  );

  assign out_tdata = {(OUT_TDATA_W - HIT_OFFSET_W - HIT_NUMBER_W)'(0), hit_number, hit_offset};

  a_hit_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (hit_number != '0))
    else $error("hit number zero on a valid result");

  a_hit_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (hit_number <= hit_limit_r))
    else $error("hit number above hit limit");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

/* sim/byte_pattern_hit_finder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_hit_finder_tb
// Drives byte files through the hit finder under a series of pattern, length
// and hit limit settings. A byte-level model predicts every hit. The monitor
// compares each hit transaction on out_ with the oldest predicted hit, under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module byte_pattern_hit_finder_tb;
  import bphf_pkg::*;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [9:0]  number;
  } hit_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;   // [7:0] data_byte
  logic                   in_tuser   = 1'b0; // [0] first_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [31:0] hit_offset, [41:32] hit_number
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  byte_item_t byte_queue[$];
  hit_t       expected_hits[$];
  byte_item_t next_item;
  hit_t       want_hit;
  int unsigned error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic       rx_hold     = 1'b0;
  logic       pressure_go = 1'b0;
  logic       start_file  = 1'b0;

  // register copies and search state
  logic [63:0] pat_lo    = '0;
  logic [63:0] pat_hi    = '0;
  logic [4:0]  pat_len   = PATTERN_LEN_RESET;
  logic [9:0]  hit_cap   = HIT_LIMIT_RESET;
  logic [7:0]  win_bytes[16];
  int unsigned win_fill  = 0;
  int unsigned skip_left = 0;
  logic [31:0] next_offset = '0;
  logic [9:0]  hits_seen = '0;

  byte_pattern_hit_finder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] pattern_byte(input int unsigned j);
    logic [127:0] pat;
    pat = {pat_hi, pat_lo};
    return pat[j*8 +: 8];
  endfunction

  function automatic int unsigned used_len();
    return (pat_len > 5'd16) ? 16 : int'(pat_len);
  endfunction

  task automatic predict_hit(input logic [7:0] b, input logic first);
    int unsigned len;
    int unsigned j;
    int k;
    logic found;
    len = used_len();
    if (first) begin
      next_offset = '0;
      win_fill    = 0;
      skip_left   = 0;
      hits_seen   = '0;
    end
    for (k = 15; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    if (win_fill < 16) win_fill++;
    found = 1'b0;
    if (skip_left > 0) begin
      skip_left--;
    end else if (len > 0 && win_fill >= len) begin
      found = 1'b1;
      for (j = 0; j < len; j++) begin
        if (win_bytes[len-1-j] != pattern_byte(j)) found = 1'b0;
      end
    end
    if (found) begin
      skip_left = len - 1;
      if (hits_seen < hit_cap) begin
        hits_seen = hits_seen + 10'd1;
        expected_hits.push_back('{offset: next_offset - 32'(len - 1), number: hits_seen});
      end
    end
    next_offset = next_offset + 32'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 30)
      $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_hit(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_item = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.data;
          in_tuser  <= next_item.first;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected hit offset", '0, out_tdata[31:0]);
        end else begin
          want_hit = expected_hits.pop_front();
          if (out_tdata[31:0] != want_hit.offset)
            report_mismatch("hit_offset", want_hit.offset, out_tdata[31:0]);
          if (out_tdata[41:32] != want_hit.number)
            report_mismatch("hit_number", 32'(want_hit.number), 32'(out_tdata[41:32]));
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // hold off the receiver while the sender keeps offering bytes
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PATTERN_LOW:  pat_lo  = value;
      REG_PATTERN_HIGH: pat_hi  = value;
      REG_PATTERN_LEN:  pat_len = value[4:0];
      REG_HIT_LIMIT:    hit_cap = value[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_queue.push_back('{first: start_file, data: b});
    start_file = 1'b0;
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_tvalid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_random_config();
    logic [127:0] pat;
    logic [7:0]   sym_a;
    logic [7:0]   sym_b;
    int unsigned  r;
    int unsigned  j;
    logic [4:0]   len;
    logic [9:0]   limit;
    r = $urandom_range(99, 0);
    if (r < 15) len = 5'd16;
    else if (r < 35) len = 5'($urandom_range(15, 5));
    else len = 5'($urandom_range(4, 1));
    // two-symbol patterns give self-overlapping matches
    if ($urandom_range(9, 0) < 4) begin
      sym_a = 8'($urandom_range(255, 0));
      sym_b = 8'($urandom_range(255, 0));
      for (j = 0; j < 16; j++) pat[j*8 +: 8] = $urandom_range(1, 0) ? sym_a : sym_b;
    end else begin
      pat = {$urandom, $urandom, $urandom, $urandom};
    end
    r = $urandom_range(99, 0);
    if (r < 10) limit = 10'd0;
    else if (r < 30) limit = 10'($urandom_range(5, 1));
    else if (r < 45) limit = 10'd1023;
    else limit = HIT_LIMIT_RESET;
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LEN, 64'(len));
    write_reg(REG_HIT_LIMIT, 64'(limit));
  endtask

  task automatic gen_stream(input int unsigned count);
    int unsigned made;
    int unsigned plen;
    int unsigned cut;
    int unsigned r;
    int unsigned j;
    made = 0;
    plen = used_len();
    start_file = ($urandom_range(1, 0) == 1);
    while (made < count) begin
      r = $urandom_range(99, 0);
      if (r < 4) begin
        start_file = 1'b1;
      end else if (r < 50 && plen > 0) begin
        for (j = 0; j < plen; j++) queue_byte(pattern_byte(j));
        made += plen;
      end else if (r < 65 && plen > 1) begin
        cut = $urandom_range(plen - 1, 1);
        for (j = 0; j < cut; j++) queue_byte(pattern_byte(j));
        queue_byte(8'($urandom_range(255, 0)));
        made += cut + 1;
      end else if (r < 80 && plen > 0) begin
        queue_byte(pattern_byte($urandom_range(plen - 1, 0)));
        made++;
      end else begin
        queue_byte(8'($urandom_range(255, 0)));
        made++;
      end
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned j;
    for (j = 0; j < 16; j++) win_bytes[j] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default single zero-byte pattern, new file on the first byte
    start_file = 1'b1;
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    wait_idle();

    // empty pattern never matches
    write_reg(REG_PATTERN_LEN, 64'd0);
    queue_byte(8'h00);
    queue_byte(8'h00);
    wait_idle();

    // overlong length counts as sixteen bytes
    write_reg(REG_PATTERN_LOW, '1);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_PATTERN_LEN, 64'd31);
    start_file = 1'b1;
    for (j = 0; j < 16; j++) queue_byte(8'hFF);
    wait_idle();

    // limit reached: second match still covers its start positions
    write_reg(REG_PATTERN_LOW, 64'h8080);
    write_reg(REG_PATTERN_LEN, 64'd2);
    write_reg(REG_HIT_LIMIT, 64'd1);
    start_file = 1'b1;
    for (j = 0; j < 4; j++) queue_byte(8'h80);
    wait_idle();

    for (p = 0; p < 10; p++) begin
      set_random_config();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 4) begin
        write_reg(REG_PATTERN_LEN, 64'd1);
        write_reg(REG_HIT_LIMIT, 64'd1023);
        pressure_go = 1'b1;
      end
      gen_stream(150);
      wait_idle();
    end

    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
